// ----- rtl/core/priority_task_scheduler_with_delays_defines.svh -----
// Assertion macros for the priority task scheduler.
// Used by the top level; expects signals named clk and rst in scope.
`ifndef PRIORITY_TASK_SCHEDULER_WITH_DELAYS_DEFINES_SVH
`define PRIORITY_TASK_SCHEDULER_WITH_DELAYS_DEFINES_SVH

// The condition must never hold outside reset.
`define PTS_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("scheduler check failed");

// The antecedent implies the consequent in the next cycle.
`define PTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

// ----- rtl/core/pts_pkg.sv -----
// Shared types for the priority task scheduler: slot states, commands and
// the per-cell control bundle. No dependencies.
`default_nettype none

package pts_pkg;

  typedef enum logic [1:0] {
    ST_UNINIT  = 2'd0,
    ST_READY   = 2'd1,
    ST_BLOCKED = 2'd2,
    ST_RUNNING = 2'd3
  } slot_state_t;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SELECT = 2'd1,
    CMD_DELAY  = 2'd2,
    CMD_START  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_START,
    OP_WAKE,
    OP_BLOCK,
    OP_SELECT
  } cell_op_t;

  // Control broadcast to one cell.
  typedef struct packed {
    cell_op_t op;
    logic     sel;  // this slot won the priority scan
    logic     cur;  // this slot is the current task
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/pts_cell.sv -----
// One task slot of the scheduler: slot state, wake time and one stage of the
// registered priority scan chain. Depends on pts_pkg.
`default_nettype none

module pts_cell #(
  parameter int IDX           = 0,
  parameter int TASK_SLOTS    = 8,
  parameter int PRIORITY_BITS = 4,
  localparam int IW           = $clog2(TASK_SLOTS)
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire pts_pkg::cell_ctl_t       ctl,
  input  wire logic                     en,
  input  wire logic [PRIORITY_BITS-1:0] prio,
  input  wire logic [31:0]              time_val,
  input  wire logic                     cand_found_in,
  input  wire logic [IW-1:0]            cand_idx_in,
  input  wire logic [PRIORITY_BITS-1:0] cand_prio_in,
  output logic                          ready,
  output logic                          running,
  output logic                          cand_found_out,
  output logic [IW-1:0]                 cand_idx_out,
  output logic [PRIORITY_BITS-1:0]      cand_prio_out
);
  import pts_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  slot_state_t st, st_next;
  logic [31:0] wake;
  logic        take;

  always_comb begin
    st_next = st;
    unique case (ctl.op)
      OP_START: st_next = en ? ST_READY : ST_UNINIT;
      OP_WAKE: begin
        if (st == ST_BLOCKED && time_val >= wake) st_next = ST_READY;
      end
      OP_BLOCK: begin
        if (ctl.cur) st_next = ST_BLOCKED;
      end
      OP_SELECT: begin
        if (ctl.sel) st_next = ST_RUNNING;
        else if (ctl.cur && st == ST_RUNNING) st_next = ST_READY;
      end
      default: st_next = st;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_UNINIT;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_BLOCK && ctl.cur) wake <= time_val;
  end

  // A later slot replaces the candidate only on strictly higher priority.
  assign take = (st == ST_READY) && (!cand_found_in || prio > cand_prio_in);

  always_ff @(posedge clk) begin
    cand_found_out <= cand_found_in || (st == ST_READY);
    cand_idx_out   <= take ? MY_IDX : cand_idx_in;
    cand_prio_out  <= take ? prio : cand_prio_in;
  end

  assign ready   = (st == ST_READY);
  assign running = (st == ST_RUNNING);

endmodule

`default_nettype wire

// ----- rtl/core/priority_task_scheduler_with_delays.sv -----
// From input transfer to result valid: start and delay pass through S_REPORT, tick
// through S_TICK and S_REPORT, select through S_SCAN (the registered scan chain through
// the cells), S_APPLY and S_REPORT. One command at a time: s_tready is high only in S_IDLE.
// Reset (rst, synchronous, active high): all slots uninitialized, tick counter,
// current task and outputs cleared, enable mask 1, priorities 0. Wake times
// are not reset and need no clearing pass.
`default_nettype none

`include "priority_task_scheduler_with_delays_defines.svh"

module priority_task_scheduler_with_delays #(
  parameter int TASK_SLOTS    = 8,
  parameter int PRIORITY_BITS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // Command stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] delay_ticks
  input  wire logic [1:0]  s_tuser,   // [1:0] command
  // Result stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // [2:0] running_slot, [3] running_valid,
                                      // [4] switch_request, [12:5] ready_mask,
                                      // [15:13] zero
);
  import pts_pkg::*;

  localparam int IW = $clog2(TASK_SLOTS);
  localparam int PB = PRIORITY_BITS;
  localparam logic [IW-1:0] SCAN_LAST = IW'(TASK_SLOTS - 1);
  localparam logic [0:0] REG_ENABLE_MASK = 1'b0;
  localparam logic [0:0] REG_PRIORITIES  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_SCAN,
    S_APPLY,
    S_REPORT
  } fsm_t;

  fsm_t        state;
  logic [7:0]  task_enable_mask;
  logic [31:0] task_priorities;
  logic [31:0] tick_counter;
  logic [IW-1:0] current_index;
  logic        current_present;
  logic        sw_pend;
  logic [IW-1:0] scan_cnt;

  cmd_t        cmd;
  logic        accept;
  logic [31:0] time_bus;
  cell_op_t    op;

  // Scan chain taps: position i feeds cell i, position TASK_SLOTS is the end.
  logic [TASK_SLOTS:0] cf;
  logic [IW-1:0]       ci [TASK_SLOTS+1];
  logic [PB-1:0]       cp [TASK_SLOTS+1];
  logic [TASK_SLOTS-1:0] ready_vec;
  logic [TASK_SLOTS-1:0] running_vec;
  logic [7:0]          rmask;
  logic [IW+2:0]       cur_ext;

  assign cmd      = cmd_t'(s_tuser);
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // The delay sum rides the shared time bus only during the accept cycle.
  assign time_bus = (accept && cmd == CMD_DELAY) ? tick_counter + s_tdata : tick_counter;

  always_comb begin
    op = OP_NONE;
    priority if (accept && cmd == CMD_START) begin
      op = OP_START;
    end else if (accept && cmd == CMD_DELAY && current_present) begin
      op = OP_BLOCK;
    end else if (state == S_TICK) begin
      op = OP_WAKE;
    end else if (state == S_APPLY && cf[TASK_SLOTS]) begin
      op = OP_SELECT;
    end
  end

  assign cf[0] = 1'b0;
  assign ci[0] = '0;
  assign cp[0] = '0;

  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_slot
    localparam int SH = i * PB;
    localparam logic [IW-1:0] SLOT = IW'(i);
    logic [31:0] prio_shift;
    logic        en;
    cell_ctl_t   ctl;

    // Fields reaching past bit 31 are zero filled; slots with SH of 32 or more get zero.
    assign prio_shift = (SH >= 32) ? 32'd0 : (task_priorities >> SH);
    if (i < 8) begin : g_en
      assign en = task_enable_mask[i];
    end else begin : g_noen
      assign en = 1'b0;
    end

    assign ctl.op  = op;
    assign ctl.sel = (ci[TASK_SLOTS] == SLOT);
    assign ctl.cur = current_present && (current_index == SLOT);

    pts_cell #(
      .IDX(i),
      .TASK_SLOTS(TASK_SLOTS),
      .PRIORITY_BITS(PRIORITY_BITS)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .ctl(ctl),
      .en(en),
      .prio(prio_shift[PB-1:0]),
      .time_val(time_bus),
      .cand_found_in(cf[i]),
      .cand_idx_in(ci[i]),
      .cand_prio_in(cp[i]),
      .ready(ready_vec[i]),
      .running(running_vec[i]),
      .cand_found_out(cf[i+1]),
      .cand_idx_out(ci[i+1]),
      .cand_prio_out(cp[i+1])
    );
  end

  // Only the first eight slots are reported.
  for (genvar j = 0; j < 8; j++) begin : g_rmask
    if (j < TASK_SLOTS) begin : g_on
      assign rmask[j] = ready_vec[j];
    end else begin : g_off
      assign rmask[j] = 1'b0;
    end
  end

  assign cur_ext = {3'b000, current_index};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      task_enable_mask <= 8'd1;
      task_priorities  <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE_MASK: task_enable_mask <= cfg_data[7:0];
        REG_PRIORITIES:  task_priorities  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Command sequencer with the result register. A finished result waits in
  // S_REPORT while the previous one is still held by the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      tick_counter    <= 32'd0;
      current_index   <= '0;
      current_present <= 1'b0;
      sw_pend         <= 1'b0;
      scan_cnt        <= '0;
      m_tvalid        <= 1'b0;
      m_tdata         <= '0;
    end else begin
      // In S_REPORT the result register is reloaded on a transfer instead.
      if (m_tvalid && m_tready && state != S_REPORT) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            unique case (cmd)
              CMD_TICK: begin
                tick_counter <= tick_counter + 32'd1;
                sw_pend      <= 1'b1;
                state        <= S_TICK;
              end
              CMD_SELECT: begin
                sw_pend  <= 1'b0;
                scan_cnt <= '0;
                state    <= S_SCAN;
              end
              CMD_DELAY: begin
                sw_pend <= current_present;
                state   <= S_REPORT;
              end
              CMD_START: begin
                current_present <= 1'b0;
                sw_pend         <= 1'b0;
                state           <= S_REPORT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_TICK: state <= S_REPORT;
        S_SCAN: begin
          // Let the candidate ripple through every cell of the chain.
          if (scan_cnt == SCAN_LAST) begin
            state <= S_APPLY;
          end else begin
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        S_APPLY: begin
          if (cf[TASK_SLOTS]) begin
            current_index   <= ci[TASK_SLOTS];
            current_present <= 1'b1;
          end
          state <= S_REPORT;
        end
        S_REPORT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {3'b000, rmask, sw_pend, current_present, cur_ext[2:0]};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Selection promotes one slot and demotes the old one: never two running.
  `PTS_ASSERT_NEVER(a_one_running, $countones(running_vec) > 1)
  // A select never asks for a context switch.
  `PTS_ASSERT_NEXT(a_select_no_switch, accept && cmd == CMD_SELECT, !sw_pend)
  // The scan counter stays within the chain length.
  `PTS_ASSERT_NEVER(a_scan_range, state == S_SCAN && scan_cnt > SCAN_LAST)
  // Commands are taken only with no item in flight.
  `PTS_ASSERT_NEVER(a_ready_idle, s_tready && state != S_IDLE)

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking testbench for the priority task scheduler with tick delays.
// Depends on pts_pkg and the priority_task_scheduler_with_delays top level.
`timescale 1ns / 100ps

module tb;
  import pts_pkg::*;

  localparam int SLOT_COUNT   = 8;
  localparam int PRIO_WIDTH   = 4;
  // Generous bound: about 1300 commands, each at worst a long sender gap, a
  // full scan and a long receiver stall, taken roughly ten times over.
  localparam int LIMIT_CYCLES = 400000;
  // Cycles allowed after the last result for anything stray to show up.
  localparam int TAIL_CYCLES  = 2 * SLOT_COUNT + 8;

  localparam logic [0:0] REG_ENABLE_MASK = 1'b0;
  localparam logic [0:0] REG_PRIORITIES  = 1'b1;

  // One scheduler command as it travels on the command stream.
  typedef struct {
    cmd_t        command;
    logic [31:0] delay_ticks;
  } sched_cmd_t;

  // One status word as it travels on the result stream.
  typedef struct {
    logic [2:0] running_slot;
    logic       running_valid;
    logic       switch_request;
    logic [7:0] ready_mask;
  } sched_status_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_ENABLE_MASK;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] delay_ticks
  logic [1:0]  s_tuser = CMD_TICK;  // [1:0] command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [2:0] running_slot, [3] running_valid,
                               // [4] switch_request, [12:5] ready_mask

  priority_task_scheduler_with_delays #(
    .TASK_SLOTS   (SLOT_COUNT),
    .PRIORITY_BITS(PRIO_WIDTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  // Commands waiting to be driven and status words still owed by the block.
  sched_cmd_t    cmd_backlog[$];
  sched_status_t status_owed[$];

  int unsigned cmds_queued = 0;
  int unsigned cmds_taken = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        cmd_xfer = 1'b0;

  // Scheduler state as the testbench sees it, plus its copy of the registers.
  slot_state_t slot_mode[SLOT_COUNT];
  logic [31:0] wake_at[SLOT_COUNT];
  logic [31:0] tick_now;
  logic [2:0]  cur_slot;
  logic        cur_valid;
  logic [7:0]  enable_bits;
  logic [31:0] prio_word;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Applies one command to the scheduler state and returns the status word
  // the block should report for it.
  task automatic schedule_step(input sched_cmd_t c, output sched_status_t st);
    logic        found;
    int          best;
    logic [3:0]  best_prio;
    logic [3:0]  p;
    logic        sw;
    found = 1'b0;
    best = 0;
    best_prio = '0;
    sw = 1'b0;
    case (c.command)
      CMD_TICK: begin
        tick_now = tick_now + 32'd1;
        for (int i = 0; i < SLOT_COUNT; i++)
          if (slot_mode[i] == ST_BLOCKED && tick_now >= wake_at[i])
            slot_mode[i] = ST_READY;
        sw = 1'b1;
      end
      CMD_SELECT: begin
        // Strictly greater wins, so the lowest index keeps a tie.
        for (int i = 0; i < SLOT_COUNT; i++) begin
          p = prio_word[i*PRIO_WIDTH +: PRIO_WIDTH];
          if (slot_mode[i] == ST_READY && (!found || p > best_prio)) begin
            found = 1'b1;
            best = i;
            best_prio = p;
          end
        end
        if (found) begin
          // A blocked current task stays blocked; only a running one yields.
          if (cur_valid && slot_mode[cur_slot] == ST_RUNNING)
            slot_mode[cur_slot] = ST_READY;
          slot_mode[best] = ST_RUNNING;
          cur_slot = best[2:0];
          cur_valid = 1'b1;
        end
      end
      CMD_DELAY: begin
        // With no current task the delay is dropped and no switch is asked.
        if (cur_valid) begin
          wake_at[cur_slot] = tick_now + c.delay_ticks;
          slot_mode[cur_slot] = ST_BLOCKED;
          sw = 1'b1;
        end
      end
      default: begin
        for (int i = 0; i < SLOT_COUNT; i++)
          slot_mode[i] = enable_bits[i] ? ST_READY : ST_UNINIT;
        cur_valid = 1'b0;
      end
    endcase
    st.running_slot = cur_slot;
    st.running_valid = cur_valid;
    st.switch_request = sw;
    for (int i = 0; i < SLOT_COUNT; i++)
      st.ready_mask[i] = (slot_mode[i] == ST_READY);
  endtask

  // Monitor: tracks register writes, predicts each accepted command and
  // checks each result transfer against the oldest owed status word.
  always @(posedge clk) begin : monitor
    sched_cmd_t    taken;
    sched_status_t got;
    sched_status_t want;
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_mode[i] = ST_UNINIT;
        wake_at[i] = '0;
      end
      tick_now = '0;
      cur_slot = '0;
      cur_valid = 1'b0;
      enable_bits = 8'h01;
      prio_word = '0;
      cmd_xfer <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLE_MASK: enable_bits = cfg_data[7:0];
          REG_PRIORITIES:  prio_word = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.running_slot = m_tdata[2:0];
        got.running_valid = m_tdata[3];
        got.switch_request = m_tdata[4];
        got.ready_mask = m_tdata[12:5];
        if (status_owed.size() == 0) begin
          report_mismatch("unexpected result transfer", int'(m_tdata), 0);
        end else begin
          want = status_owed.pop_front();
          if (got.running_slot !== want.running_slot)
            report_mismatch("running_slot", int'(got.running_slot),
                            int'(want.running_slot));
          if (got.running_valid !== want.running_valid)
            report_mismatch("running_valid", int'(got.running_valid),
                            int'(want.running_valid));
          if (got.switch_request !== want.switch_request)
            report_mismatch("switch_request", int'(got.switch_request),
                            int'(want.switch_request));
          if (got.ready_mask !== want.ready_mask)
            report_mismatch("ready_mask", int'(got.ready_mask), int'(want.ready_mask));
        end
      end
      if (s_tvalid && s_tready) begin
        taken.command = cmd_t'(s_tuser);
        taken.delay_ticks = s_tdata;
        schedule_step(taken, want);
        status_owed.push_back(want);
        cmds_taken++;
      end
      cmd_xfer <= s_tvalid && s_tready;
    end
  end

  // Driver: holds a command until its transfer, then offers the next one
  // from the backlog unless the sender decides to idle this cycle.
  always @(negedge clk) begin : driver
    sched_cmd_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || cmd_xfer) begin
      if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = cmd_backlog.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= nxt.command;
        s_tdata <= nxt.delay_ticks;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // The result side stalls with the probability of the current phase.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_cmd(input cmd_t c, input logic [31:0] ticks);
    sched_cmd_t item;
    item.command = c;
    item.delay_ticks = ticks;
    cmd_backlog.push_back(item);
    cmds_queued++;
  endtask

  // Random command mix: mostly ticks, selects and delays, with an occasional
  // start that throws the enabled slots back to ready. Short delays dominate
  // so that blocked tasks wake within the run; some delays span all 32 bits.
  task automatic push_random_cmd();
    int unsigned w;
    int unsigned r;
    logic [31:0] ticks;
    cmd_t c;
    w = $urandom_range(0, 99);
    r = $urandom_range(0, 99);
    if (w < 35) c = CMD_TICK;
    else if (w < 65) c = CMD_SELECT;
    else if (w < 95) c = CMD_DELAY;
    else c = CMD_START;
    if (c != CMD_DELAY || r >= 85) ticks = $urandom();
    else if (r < 60) ticks = $urandom_range(0, 12);
    else ticks = $urandom_range(0, 64);
    push_cmd(c, ticks);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued command has been taken and every owed status
  // word has come back, then lets the block's longest latency pass.
  task automatic wait_drained();
    while (cmds_taken != cmds_queued || status_owed.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // One random phase under a fixed register setting. Each phase opens with a
  // start so that the task set is live. With hold_mid set, the sender stops
  // halfway until every status word is back before going on.
  task automatic run_phase(input logic [7:0] en, input logic [31:0] prio,
                           input int unsigned idle, input int unsigned stall,
                           input int count, input bit hold_mid);
    write_reg(REG_ENABLE_MASK, {24'd0, en});
    write_reg(REG_PRIORITIES, prio);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    @(posedge clk);
    push_cmd(CMD_START, $urandom());
    for (int i = 1; i < count; i++) begin
      if (hold_mid && i == count / 2) begin
        wait_drained();
        @(posedge clk);
      end
      push_random_cmd();
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed part under the reset registers: only slot 0 exists.
    @(posedge clk);
    push_cmd(CMD_TICK, 32'h0000_0000);
    push_cmd(CMD_SELECT, 32'hFFFF_FFFF);    // nothing is ready yet
    push_cmd(CMD_DELAY, 32'h0000_0007);     // no current task, dropped
    push_cmd(CMD_START, 32'h0000_0000);
    push_cmd(CMD_SELECT, 32'h0000_0000);
    push_cmd(CMD_DELAY, 32'h0000_0000);     // wakes on the very next tick
    push_cmd(CMD_SELECT, 32'h0000_0000);    // nothing ready, current kept
    push_cmd(CMD_TICK, 32'h0000_0000);
    push_cmd(CMD_SELECT, 32'h0000_0000);
    wait_drained();

    // Directed part with every slot present; slots 0 and 3 share the top
    // priority so the tie goes to slot 0.
    write_reg(REG_ENABLE_MASK, 32'h0000_00FF);
    write_reg(REG_PRIORITIES, 32'h0000_F00F);
    @(posedge clk);
    push_cmd(CMD_START, 32'h0000_0000);
    push_cmd(CMD_SELECT, 32'h0000_0000);
    push_cmd(CMD_DELAY, 32'hFFFF_FFFF);     // wake time wraps below the counter
    push_cmd(CMD_SELECT, 32'h0000_0000);    // blocked current is replaced
    push_cmd(CMD_SELECT, 32'h0000_0000);    // running slot 3 yields to slot 1
    push_cmd(CMD_TICK, 32'h0000_0000);
    push_cmd(CMD_SELECT, 32'h0000_0000);
    push_cmd(CMD_DELAY, 32'h8000_0000);     // effectively never wakes
    push_cmd(CMD_SELECT, 32'h0000_0000);
    push_cmd(CMD_DELAY, 32'h0000_0002);
    push_cmd(CMD_TICK, 32'h0000_0000);
    push_cmd(CMD_TICK, 32'h0000_0000);      // wake time reached exactly
    push_cmd(CMD_SELECT, 32'h0000_0000);
    wait_drained();

    // Random phases across the idling modes and register settings,
    // extremes included.
    run_phase(8'hFF, 32'hFFFF_FFFF, 0, 0, 250, 1'b0);
    run_phase(8'hFF, $urandom(), 83, 0, 250, 1'b1);
    run_phase($urandom_range(1, 255), $urandom(), 0, 83, 250, 1'b0);
    run_phase(8'h00, 32'h0000_0000, 19, 19, 30, 1'b0);
    run_phase($urandom_range(0, 255), 32'h7654_3210, 19, 19, 250, 1'b0);
    run_phase(8'h81, $urandom(), 0, 0, 250, 1'b0);

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
